### design/xkb64_pkg.sv
// Shared types, constants and lookup functions for the XOR/Base64 obfuscator.
package xkb64_pkg;

  localparam int KEY_BYTES    = 16;
  localparam int PREFIX_CHARS = 5;
  localparam int PFX_LEN      = (PREFIX_CHARS < 1) ? 1 : ((PREFIX_CHARS > 5) ? 5 : PREFIX_CHARS);
  localparam int KEY_W        = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int PP_W         = $clog2(PFX_LEN + 1);
  localparam int MAX_RES      = 9;
  localparam int CNT_W        = $clog2(MAX_RES + 1);
  localparam int QDEPTH       = 2;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int QCNT_W       = $clog2(QDEPTH + 1);

  // Mode register values
  localparam logic MODE_OBF   = 1'b0;
  localparam logic MODE_DEOBF = 1'b1;

  localparam logic [7:0] CH_PAD = 8'h3D;  // '='

  localparam logic [7:0] KEY_TAB [16] = '{
    8'h4D, 8'h67, 8'h2A, 8'h51, 8'h78, 8'h1F, 8'h6B, 8'h3E,
    8'h59, 8'h0C, 8'h44, 8'h73, 8'h28, 8'h65, 8'h1A, 8'h5F
  };

  // One item's results, handed from front to back
  typedef struct packed {
    logic [MAX_RES-1:0][7:0] bytes;
    logic [CNT_W-1:0]        cnt;
    logic                    dvalid;
    logic                    last;
  } bundle_t;

  // Queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Key byte for a key position; the table repeats every 16 bytes
  function automatic logic [7:0] key_byte(input logic [KEY_W-1:0] pos);
    logic [3:0] idx;
    idx = 4'(pos);
    return KEY_TAB[idx];
  endfunction

  // Prefix character "{enc}" at a position
  function automatic logic [7:0] pfx_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h7B;
      4'd1:    c = 8'h65;
      4'd2:    c = 8'h6E;
      4'd3:    c = 8'h63;
      4'd4:    c = 8'h7D;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Base64 alphabet
  function automatic logic [7:0] b64_enc(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26)      c = 8'h41 + 8'(v);
    else if (v < 6'd52) c = 8'h61 + 8'(v - 6'd26);
    else if (v < 6'd62) c = 8'h30 + 8'(v - 6'd52);
    else if (v == 6'd62) c = 8'h2B;
    else                 c = 8'h2F;
    return c;
  endfunction

  // Base64 character to value; bit 6 set when the character is valid
  function automatic logic [6:0] b64_dec(input logic [7:0] c);
    logic [6:0] r;
    if (c >= 8'h41 && c <= 8'h5A)      r = {1'b1, 6'(c - 8'h41)};
    else if (c >= 8'h61 && c <= 8'h7A) r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    else if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    else if (c == 8'h2B)               r = {1'b1, 6'd62};
    else if (c == 8'h2F)               r = {1'b1, 6'd63};
    else                               r = 7'd0;
    return r;
  endfunction

endpackage

### design/xor_key_base64_obfuscator_unit.sv
// Top level of the repeating-key XOR obfuscator with Base64 armour.
//
// Input stream s_*: one message byte per item, s_tlast on the final byte.
// Output stream m_*: one character or decoded byte per item; m_tuser[0] is 1
// for data and 0 for the empty end marker (data 0); m_tlast ends the message.
// mode_we/mode_wdata write the mode (0 obfuscate, 1 deobfuscate) and restart
// the message; write it only while the block is idle.
// Throughput: a byte is accepted each cycle while the two-entry result queue
// has room; the output register drains one result per cycle while the receiver
// is ready, and an item yields 0 to 9 results (about 4/3 per byte in a
// long obfuscated message, at most 1 per byte when decoding or passing through).
// An accepted item's results are written into the queue at the accepting edge;
// the output register loads them from the queue once it is free.
// Reset clears mode and all message state and empties the queue. When the
// receiver stalls, the output register holds, the queue fills and s_tready
// falls; nothing is lost.
module xor_key_base64_obfuscator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        mode_we,
  input  logic        mode_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic [0:0]  m_tuser,   // [0] out_data_valid
  output logic        m_tlast
);

  xkb64_pkg::bundle_t wr_bundle;
  xkb64_pkg::bundle_t head;
  xkb64_pkg::qstat_t  qstat;
  logic               push;
  logic               pop;

  xkb64_front u_front (
    .clk        (clk),
    .rst        (rst),
    .mode_we    (mode_we),
    .mode_wdata (mode_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .qstat      (qstat),
    .push       (push),
    .bundle     (wr_bundle)
  );

  xkb64_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_bundle (wr_bundle),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  xkb64_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .qstat    (qstat),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

`ifndef SYNTH
  // An end marker is always the final result and carries zero data
  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata == 8'h00)
    else $error("end marker without last or with data");

  // Nothing left to send: output goes idle after the current result is taken
  a_drain_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && qstat.empty |=> !m_tvalid)
    else $error("output valid with an empty queue");

  // Reset empties the output and the queue
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid && qstat.empty)
    else $error("state left after reset");

  // A bundle is taken from the queue only when the output can accept a byte
  a_pop_ok: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty && (!m_tvalid || m_tready))
    else $error("queue popped without room at the output");
`endif

endmodule

### design/xkb64_front.sv
// Front end: accepts bytes, tracks message state and builds each item's results.
module xkb64_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                mode_we,
  input  logic                mode_wdata,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,
  input  logic                s_tlast,
  input  xkb64_pkg::qstat_t   qstat,
  output logic                push,
  output xkb64_pkg::bundle_t  bundle
);

  logic                           mode;
  logic [xkb64_pkg::KEY_W-1:0]    key_position, key_position_next;
  logic [1:0]                     group_phase, group_phase_next;
  logic [5:0]                     carry_bits, carry_bits_next;
  logic [xkb64_pkg::PP_W-1:0]     prefix_position, prefix_position_next;
  logic                           pass_through, pass_through_next;
  logic                           pad_seen, pad_seen_next;

  logic                           accept;

  assign s_tready = !qstat.full;
  assign accept   = s_tvalid && s_tready;
  assign push     = accept && (bundle.cnt != '0);

  // Build the result list and the next message state
  always_comb begin
    logic [7:0]                    x;
    logic [7:0]                    b;
    logic [6:0]                    dv;
    logic [xkb64_pkg::CNT_W-1:0]   n;
    logic                          use_key;
    for (int i = 0; i < xkb64_pkg::MAX_RES; i++) begin
      bundle.bytes[i] = (i < xkb64_pkg::PFX_LEN) ? xkb64_pkg::pfx_char(4'(i)) : 8'h00;
    end
    n       = '0;
    b       = 8'h00;
    use_key = 1'b0;
    x       = s_tdata ^ xkb64_pkg::key_byte(key_position);
    dv      = xkb64_pkg::b64_dec(s_tdata);
    key_position_next    = key_position;
    group_phase_next     = group_phase;
    carry_bits_next      = carry_bits;
    prefix_position_next = prefix_position;
    pass_through_next    = pass_through;
    pad_seen_next        = pad_seen;
    bundle.dvalid        = 1'b1;

    if (!mode) begin
      // Obfuscate: prefix once, then Base64 of the keyed byte
      use_key = 1'b1;
      if (prefix_position == '0) begin
        n = xkb64_pkg::CNT_W'(xkb64_pkg::PFX_LEN);
        prefix_position_next = xkb64_pkg::PP_W'(xkb64_pkg::PFX_LEN);
      end
      case (group_phase)
        2'd0: begin
          bundle.bytes[n] = xkb64_pkg::b64_enc(x[7:2]);
          n = n + 1'b1;
          carry_bits_next = {4'd0, x[1:0]};
          group_phase_next = 2'd1;
        end
        2'd1: begin
          bundle.bytes[n] = xkb64_pkg::b64_enc({carry_bits[1:0], x[7:4]});
          n = n + 1'b1;
          carry_bits_next = {2'd0, x[3:0]};
          group_phase_next = 2'd2;
        end
        default: begin
          bundle.bytes[n] = xkb64_pkg::b64_enc({carry_bits[3:0], x[7:6]});
          n = n + 1'b1;
          bundle.bytes[n] = xkb64_pkg::b64_enc(x[5:0]);
          n = n + 1'b1;
          carry_bits_next = 6'd0;
          group_phase_next = 2'd0;
        end
      endcase
      // Flush a partial group with padding at the end of the message
      if (s_tlast) begin
        if (group_phase_next == 2'd1) begin
          bundle.bytes[n] = xkb64_pkg::b64_enc({carry_bits_next[1:0], 4'd0});
          n = n + 1'b1;
          bundle.bytes[n] = xkb64_pkg::CH_PAD;
          n = n + 1'b1;
          bundle.bytes[n] = xkb64_pkg::CH_PAD;
          n = n + 1'b1;
        end else if (group_phase_next == 2'd2) begin
          bundle.bytes[n] = xkb64_pkg::b64_enc({carry_bits_next[3:0], 2'd0});
          n = n + 1'b1;
          bundle.bytes[n] = xkb64_pkg::CH_PAD;
          n = n + 1'b1;
        end
      end
    end else begin
      // Deobfuscate: match prefix, then decode
      if (pass_through) begin
        bundle.bytes[0] = s_tdata;
        n = xkb64_pkg::CNT_W'(1);
      end else if (prefix_position < xkb64_pkg::PP_W'(xkb64_pkg::PFX_LEN)) begin
        if (s_tdata == xkb64_pkg::pfx_char(4'(prefix_position))) begin
          prefix_position_next = prefix_position + 1'b1;
        end else begin
          // Mismatch: replay matched prefix, then this byte, then pass
          bundle.bytes[4'(prefix_position)] = s_tdata;
          n = xkb64_pkg::CNT_W'(prefix_position) + 1'b1;
          pass_through_next = 1'b1;
        end
      end else if (!pad_seen) begin
        if (s_tdata == xkb64_pkg::CH_PAD) begin
          pad_seen_next = 1'b1;
        end else if (dv[6]) begin
          case (group_phase)
            2'd0: begin
              carry_bits_next = dv[5:0];
              group_phase_next = 2'd1;
            end
            2'd1: begin
              b = {carry_bits[5:0], dv[5:4]};
              carry_bits_next = {2'd0, dv[3:0]};
              group_phase_next = 2'd2;
              use_key = 1'b1;
            end
            2'd2: begin
              b = {carry_bits[3:0], dv[5:2]};
              carry_bits_next = {4'd0, dv[1:0]};
              group_phase_next = 2'd3;
              use_key = 1'b1;
            end
            default: begin
              b = {carry_bits[1:0], dv[5:0]};
              carry_bits_next = 6'd0;
              group_phase_next = 2'd0;
              use_key = 1'b1;
            end
          endcase
          if (use_key) begin
            bundle.bytes[0] = b ^ xkb64_pkg::key_byte(key_position);
            n = xkb64_pkg::CNT_W'(1);
          end
        end
      end
      // Short message ending inside the prefix: replay what matched
      if (s_tlast && n == '0 &&
          prefix_position_next < xkb64_pkg::PP_W'(xkb64_pkg::PFX_LEN)) begin
        n = xkb64_pkg::CNT_W'(prefix_position_next);
      end
    end

    // Advance the key position on every keyed byte
    if (use_key) begin
      if (key_position == xkb64_pkg::KEY_W'(xkb64_pkg::KEY_BYTES - 1)) begin
        key_position_next = '0;
      end else begin
        key_position_next = key_position + 1'b1;
      end
    end

    // Empty end marker when the last byte yields nothing
    if (s_tlast && n == '0) begin
      bundle.bytes[0] = 8'h00;
      bundle.dvalid   = 1'b0;
      n = xkb64_pkg::CNT_W'(1);
    end
    bundle.cnt  = n;
    bundle.last = s_tlast;
  end

  // Hold mode and message state; a mode write or a last byte starts afresh
  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= 1'b0;
      key_position    <= '0;
      group_phase     <= '0;
      carry_bits      <= '0;
      prefix_position <= '0;
      pass_through    <= 1'b0;
      pad_seen        <= 1'b0;
    end else if (mode_we || (accept && s_tlast)) begin
      if (mode_we) begin
        mode <= mode_wdata;
      end
      key_position    <= '0;
      group_phase     <= '0;
      carry_bits      <= '0;
      prefix_position <= '0;
      pass_through    <= 1'b0;
      pad_seen        <= 1'b0;
    end else if (accept) begin
      key_position    <= key_position_next;
      group_phase     <= group_phase_next;
      carry_bits      <= carry_bits_next;
      prefix_position <= prefix_position_next;
      pass_through    <= pass_through_next;
      pad_seen        <= pad_seen_next;
    end
  end

endmodule

### design/xkb64_queue.sv
// Short queue of result bundles between the front and back ends.
module xkb64_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  xkb64_pkg::bundle_t  wr_bundle,
  input  logic                pop,
  output xkb64_pkg::bundle_t  head,
  output xkb64_pkg::qstat_t   qstat
);

  xkb64_pkg::bundle_t            mem [xkb64_pkg::QDEPTH];
  logic [xkb64_pkg::QPTR_W-1:0]  wr_ptr;
  logic [xkb64_pkg::QPTR_W-1:0]  rd_ptr;
  logic [xkb64_pkg::QCNT_W-1:0]  count;

  assign qstat.full  = (count == xkb64_pkg::QCNT_W'(xkb64_pkg::QDEPTH));
  assign qstat.empty = (count == '0);
  assign head        = mem[rd_ptr];

  // Store pushed bundles
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_bundle;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == xkb64_pkg::QPTR_W'(xkb64_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == xkb64_pkg::QPTR_W'(xkb64_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### design/xkb64_back.sv
// Back end: serialises queued bundles into the output register, one byte a cycle unless stalled.
module xkb64_back (
  input  logic                clk,
  input  logic                rst,
  input  xkb64_pkg::bundle_t  head,
  input  xkb64_pkg::qstat_t   qstat,
  output logic                pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,
  output logic [0:0]          m_tuser,
  output logic                m_tlast
);

  logic [xkb64_pkg::CNT_W-1:0] pos;
  logic                        advance;
  logic                        load;
  logic                        at_end;

  assign advance = !m_tvalid || m_tready;
  assign load    = advance && !qstat.empty;
  assign at_end  = (pos == head.cnt - 1'b1);
  assign pop     = load && at_end;

  // Step through the head bundle and refill the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= !qstat.empty;
      if (load) begin
        pos <= at_end ? '0 : pos + 1'b1;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata    <= head.bytes[pos];
      m_tuser[0] <= head.dvalid;
      m_tlast    <= head.last && at_end;
    end
  end

endmodule

### tb/xkb64_checker.sv
// Checker for the XOR/Base64 obfuscator: predicts every result item and compares it.
`timescale 1ns / 1ps

module xkb64_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       mode_we,
  input  logic       mode_wdata,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,   // [7:0] out_byte
  input  logic [0:0] m_tuser,   // [0] out_data_valid
  input  logic       m_tlast,
  output int         fail_count,
  output int         pending,
  output int         checked
);

  localparam int         TAG_LEN    = 5;
  localparam int         MAX_BURST  = 9;
  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam logic [7:0] XOR_KEY [16] = '{
    8'h4D, 8'h67, 8'h2A, 8'h51, 8'h78, 8'h1F, 8'h6B, 8'h3E,
    8'h59, 8'h0C, 8'h44, 8'h73, 8'h28, 8'h65, 8'h1A, 8'h5F
  };
  // "{enc}"
  localparam logic [7:0] TAG [TAG_LEN] = '{8'h7B, 8'h65, 8'h6E, 8'h63, 8'h7D};

  typedef struct packed {
    logic [7:0] data;
    logic       dvalid;
    logic       last;
  } out_item_t;

  out_item_t   awaited_q[$];

  // Shadow of the block's mode and message state
  logic        dir_mode;
  logic [3:0]  key_pos;
  logic [1:0]  grp_phase;
  logic [5:0]  carry;
  logic [2:0]  tag_pos;
  logic        passing;
  logic        pad_hit;
  int          burst;
  int          fails;
  int          matched;

  function automatic void clear_message();
    key_pos   = '0;
    grp_phase = '0;
    carry     = '0;
    tag_pos   = '0;
    passing   = 1'b0;
    pad_hit   = 1'b0;
  endfunction

  // Queue one result, never more than a burst allows
  function automatic void push_out(input logic [7:0] b, input logic v);
    out_item_t r;
    r.data   = b;
    r.dvalid = v;
    r.last   = 1'b0;
    if (burst < MAX_BURST) begin
      awaited_q.push_back(r);
      burst++;
    end
  endfunction

  function automatic logic [7:0] take_key();
    logic [7:0] k;
    k       = XOR_KEY[key_pos];
    key_pos = key_pos + 4'd1;
    return k;
  endfunction

  function automatic logic [7:0] glyph(input logic [5:0] v);
    if (v < 6'd26) return 8'h41 + 8'(v);
    if (v < 6'd52) return 8'h61 + 8'(v) - 8'd26;
    if (v < 6'd62) return 8'h30 + 8'(v) - 8'd52;
    return (v == 6'd62) ? 8'h2B : 8'h2F;
  endfunction

  // Value of a Base64 character, -1 when it is not one
  function automatic int glyph_value(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) return int'(c) - 'h41;
    if (c >= 8'h61 && c <= 8'h7A) return int'(c) - 'h61 + 26;
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30 + 52;
    if (c == 8'h2B) return 62;
    if (c == 8'h2F) return 63;
    return -1;
  endfunction

  function automatic void encode_byte(input logic [7:0] c, input logic fin);
    logic [7:0] x;
    int         i;
    if (tag_pos == 3'd0) begin
      for (i = 0; i < TAG_LEN; i++) push_out(TAG[i], 1'b1);
      tag_pos = 3'(TAG_LEN);
    end
    x = c ^ take_key();
    case (grp_phase)
      2'd0: begin
        push_out(glyph(x[7:2]), 1'b1);
        carry     = {4'b0, x[1:0]};
        grp_phase = 2'd1;
      end
      2'd1: begin
        push_out(glyph({carry[1:0], x[7:4]}), 1'b1);
        carry     = {2'b0, x[3:0]};
        grp_phase = 2'd2;
      end
      default: begin
        push_out(glyph({carry[3:0], x[7:6]}), 1'b1);
        push_out(glyph(x[5:0]), 1'b1);
        carry     = '0;
        grp_phase = 2'd0;
      end
    endcase
    // Flush a partial group with padding at the end of the message
    if (fin) begin
      if (grp_phase == 2'd1) begin
        push_out(glyph({carry[1:0], 4'b0}), 1'b1);
        push_out(PAD_CHAR, 1'b1);
        push_out(PAD_CHAR, 1'b1);
      end else if (grp_phase == 2'd2) begin
        push_out(glyph({carry[3:0], 2'b0}), 1'b1);
        push_out(PAD_CHAR, 1'b1);
      end
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] c);
    int         d;
    int         i;
    logic [7:0] b;
    if (passing) begin
      push_out(c, 1'b1);
      return;
    end
    // Match the tag; on a mismatch replay what matched and pass the rest
    if (tag_pos < 3'(TAG_LEN)) begin
      if (c == TAG[tag_pos]) begin
        tag_pos = tag_pos + 3'd1;
      end else begin
        for (i = 0; i < int'(tag_pos); i++) push_out(TAG[i], 1'b1);
        push_out(c, 1'b1);
        passing = 1'b1;
      end
      return;
    end
    if (pad_hit) return;
    if (c == PAD_CHAR) begin
      pad_hit = 1'b1;
      return;
    end
    d = glyph_value(c);
    if (d < 0) return;
    case (grp_phase)
      2'd0: begin
        carry     = 6'(d);
        grp_phase = 2'd1;
        return;
      end
      2'd1: begin
        b         = {carry, 2'(d >> 4)};
        carry     = {2'b0, 4'(d)};
        grp_phase = 2'd2;
      end
      2'd2: begin
        b         = {carry[3:0], 4'(d >> 2)};
        carry     = {4'b0, 2'(d)};
        grp_phase = 2'd3;
      end
      default: begin
        b         = {carry[1:0], 6'(d)};
        carry     = '0;
        grp_phase = 2'd0;
      end
    endcase
    push_out(b ^ take_key(), 1'b1);
  endfunction

  // Work out every result that one accepted input item causes
  function automatic void predict_item(input logic [7:0] c, input logic fin);
    out_item_t r;
    int        i;
    burst = 0;
    if (dir_mode == xkb64_pkg::MODE_OBF) begin
      encode_byte(c, fin);
    end else begin
      decode_byte(c);
      if (fin && !passing && burst == 0 && tag_pos < 3'(TAG_LEN))
        for (i = 0; i < int'(tag_pos); i++) push_out(TAG[i], 1'b1);
    end
    if (fin) begin
      if (burst == 0) push_out(8'h00, 1'b0);
      r      = awaited_q.pop_back();
      r.last = 1'b1;
      awaited_q.push_back(r);
      clear_message();
    end
  endfunction

  // Compare outputs first, then take config writes and new input items
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      dir_mode = xkb64_pkg::MODE_OBF;
      clear_message();
      awaited_q.delete();
      fails    = 0;
      matched  = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (awaited_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected item, got data=%h user=%b last=%b",
                   $time, m_tdata, m_tuser, m_tlast);
        end else begin
          want = awaited_q.pop_front();
          matched++;
          if (m_tdata !== want.data || m_tuser[0] !== want.dvalid ||
              m_tlast !== want.last) begin
            fails++;
            $display("%0t: mismatch, expected data=%h user=%b last=%b,",
                     $time, want.data, want.dvalid, want.last,
                     " got data=%h user=%b last=%b", m_tdata, m_tuser, m_tlast);
          end
        end
      end
      if (mode_we) begin
        dir_mode = mode_wdata;
        clear_message();
      end
      if (s_tvalid && s_tready) predict_item(s_tdata, s_tlast);
    end
    fail_count <= fails;
    pending    <= awaited_q.size();
    checked    <= matched;
  end

endmodule

### tb/tb_xor_key_base64_obfuscator_unit.sv
// Testbench top for the XOR/Base64 obfuscator: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_xor_key_base64_obfuscator_unit;

  localparam int         STALL_LIMIT  = 1000;
  localparam int         RANDOM_ITEMS = 175;
  localparam int         PHASE_ITEMS  = 35;
  localparam int         HOLD_CYCLES  = 80;
  localparam logic [7:0] PAD_CHAR     = 8'h3D;
  // "{enc}"
  localparam logic [7:0] TAG [5] = '{8'h7B, 8'h65, 8'h6E, 8'h63, 8'h7D};

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       mode_we    = 1'b0;
  logic       mode_wdata = 1'b0;
  logic       s_tvalid   = 1'b0;
  logic [7:0] s_tdata    = 8'h00;
  logic       s_tlast    = 1'b0;
  logic       m_tready   = 1'b0;
  wire        s_tready;
  wire        m_tvalid;
  wire  [7:0] m_tdata;
  wire  [0:0] m_tuser;
  wire        m_tlast;

  int         fail_count;
  int         pending;
  int         checked;
  int         sent       = 0;
  int         phases     = 0;
  logic       cur_mode   = xkb64_pkg::MODE_OBF;
  logic       gaps_on    = 1'b1;
  logic       hold_req   = 1'b0;
  logic       hold_done  = 1'b0;
  logic [7:0] msg[$];

  xor_key_base64_obfuscator_unit dut (
    .clk        (clk),
    .rst        (rst),
    .mode_we    (mode_we),
    .mode_wdata (mode_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

  xkb64_checker chk (
    .clk        (clk),
    .rst        (rst),
    .mode_we    (mode_we),
    .mode_wdata (mode_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one item, with random gaps in front, and wait until it is taken
  task automatic send_item(input logic [7:0] b, input logic fin);
    while (gaps_on && $urandom_range(99) < 16) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= fin;
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  task automatic send_msg();
    int i;
    for (i = 0; i < msg.size(); i++) send_item(msg[i], i == msg.size() - 1);
  endtask

  task automatic load_text(input string t);
    int i;
    msg.delete();
    for (i = 0; i < t.len(); i++) msg.push_back(t[i]);
  endtask

  // Write the mode only once every result is out and the block has settled
  task automatic set_mode(input logic m);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    mode_we    <= 1'b1;
    mode_wdata <= m;
    @(posedge clk);
    mode_we    <= 1'b0;
    cur_mode   = m;
    phases++;
  endtask

  // Build one random message for the current mode
  task automatic build_random();
    int         n;
    int         k;
    int         i;
    int         kind;
    logic [7:0] c;
    msg.delete();
    if (cur_mode == xkb64_pkg::MODE_OBF) begin
      n = ($urandom_range(99) < 85) ? $urandom_range(1, 10) : $urandom_range(11, 24);
      for (i = 0; i < n; i++) msg.push_back(8'($urandom_range(255)));
      return;
    end
    kind = $urandom_range(99);
    if (kind < 65) begin
      // Tagged Base64 text with random content, some junk and padding
      for (i = 0; i < 5; i++) msg.push_back(TAG[i]);
      n = $urandom_range(1, 12);
      for (i = 0; i < n; i++) begin
        if ($urandom_range(9) == 0)
          msg.push_back($urandom_range(1) ? 8'($urandom_range(8'h2A))
                                          : 8'($urandom_range(8'h80, 8'hFF)));
        case ($urandom_range(3))
          0:       c = 8'h41 + 8'($urandom_range(25));
          1:       c = 8'h61 + 8'($urandom_range(25));
          2:       c = 8'h30 + 8'($urandom_range(9));
          default: c = $urandom_range(1) ? 8'h2B : 8'h2F;
        endcase
        msg.push_back(c);
      end
      case ($urandom_range(3))
        0: ;
        1: msg.push_back(PAD_CHAR);
        2: begin
          msg.push_back(PAD_CHAR);
          msg.push_back(PAD_CHAR);
        end
        default: begin
          msg.push_back(PAD_CHAR);
          k = $urandom_range(1, 3);
          for (i = 0; i < k; i++) msg.push_back(8'($urandom_range(255)));
        end
      endcase
    end else if (kind < 80) begin
      // Tag broken after a few characters
      k = $urandom_range(4);
      for (i = 0; i < k; i++) msg.push_back(TAG[i]);
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) msg.push_back(8'($urandom_range(255)));
    end else if (kind < 90) begin
      // Message that ends inside the tag, or right after it
      k = $urandom_range(1, 5);
      for (i = 0; i < k; i++) msg.push_back(TAG[i]);
    end else begin
      n = $urandom_range(1, 8);
      for (i = 0; i < n; i++) msg.push_back(8'($urandom_range(255)));
    end
  endtask

  // Receiver: random stalls, one long hold-off on request, calm stretches
  initial begin : sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= !gaps_on || ($urandom_range(99) >= 16);
      end
    end
  end

  // Abort when neither side moves an item for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int directed;
    int phase_start;
    int p;
    int drain;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: encoding with each padding length, longest burst first
    set_mode(xkb64_pkg::MODE_OBF);
    msg = '{8'h00};
    send_msg();
    msg = '{8'hFF, 8'h80};
    send_msg();
    msg = '{8'h01, 8'h7F, 8'hFE};
    send_msg();

    // Directed: decode with padding and end marker, broken and short tags
    set_mode(xkb64_pkg::MODE_DEOBF);
    load_text("{enc}+/=");
    send_msg();
    load_text("{x");
    send_msg();
    load_text("{e");
    send_msg();
    msg = '{8'hFF};
    send_msg();
    directed = sent;

    // Random phases, alternating direction
    p = 0;
    while (sent - directed < RANDOM_ITEMS) begin
      set_mode(p[0] ? xkb64_pkg::MODE_DEOBF : xkb64_pkg::MODE_OBF);
      phase_start = sent;
      if (p == 0) hold_req = 1'b1;
      gaps_on = (p != 2);
      while (sent - phase_start < PHASE_ITEMS) begin
        build_random();
        send_msg();
      end
      p++;
    end
    gaps_on = 1'b1;

    // Drain and let the block settle
    s_tvalid <= 1'b0;
    @(posedge clk);
    drain = 0;
    while (pending != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);

    $display("summary: %0d input items over %0d mode settings, %0d result items compared",
             sent, phases, checked);
    $display("summary: both directions, tag mismatch, short tag, padding, end marker, hold-off");
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
